// ----- hw/rtl/bscr_pkg.sv -----
`timescale 1ns / 1ps

package bscr_pkg;

  // Item operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Input line numbers
  localparam logic LINE_WPROT  = 1'b0;
  localparam logic LINE_INSERT = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOARD_ID     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROCESSOR_ID = 1'b1;

  // Board types (ID word bits 27:16)
  localparam logic [11:0] BT_MUX      = 12'h100;
  localparam logic [11:0] BT_NOMUX    = 12'h140;
  localparam logic [11:0] BT_SECOND_A = 12'h178;
  localparam logic [11:0] BT_SECOND_B = 12'h182;
  localparam logic [11:0] BT_LAST     = 12'h190;

  // Register offsets
  localparam logic [11:0] ADDR_ID          = 12'h000;
  localparam logic [11:0] ADDR_SW          = 12'h004;
  localparam logic [11:0] ADDR_LED         = 12'h008;
  localparam logic [11:0] ADDR_OSC0        = 12'h00c;
  localparam logic [11:0] ADDR_OSC1        = 12'h010;
  localparam logic [11:0] ADDR_OSC2        = 12'h014;
  localparam logic [11:0] ADDR_OSC3        = 12'h018;
  localparam logic [11:0] ADDR_OSC4        = 12'h01c;
  localparam logic [11:0] ADDR_LOCK        = 12'h020;
  localparam logic [11:0] ADDR_HUNDRED_HZ  = 12'h024;
  localparam logic [11:0] ADDR_CFGDATA1    = 12'h028;
  localparam logic [11:0] ADDR_CFGDATA2    = 12'h02c;
  localparam logic [11:0] ADDR_FLAGS       = 12'h030;
  localparam logic [11:0] ADDR_FLAGS_CLR   = 12'h034;
  localparam logic [11:0] ADDR_NVFLAGS     = 12'h038;
  localparam logic [11:0] ADDR_NVFLAGS_CLR = 12'h03c;
  localparam logic [11:0] ADDR_RESETCTL    = 12'h040;
  localparam logic [11:0] ADDR_PCICTL      = 12'h044;
  localparam logic [11:0] ADDR_CARD        = 12'h048;
  localparam logic [11:0] ADDR_FLASH       = 12'h04c;
  localparam logic [11:0] ADDR_DISP        = 12'h050;
  localparam logic [11:0] ADDR_DISP_SER    = 12'h054;
  localparam logic [11:0] ADDR_BOOTCS      = 12'h058;
  localparam logic [11:0] ADDR_COUNTER     = 12'h05c;
  localparam logic [11:0] ADDR_SPARE_60    = 12'h060;
  localparam logic [11:0] ADDR_SPARE_64    = 12'h064;
  localparam logic [11:0] ADDR_SPARE_68    = 12'h068;
  localparam logic [11:0] ADDR_SPARE_6C    = 12'h06c;
  localparam logic [11:0] ADDR_SPARE_70    = 12'h070;
  localparam logic [11:0] ADDR_SPARE_74    = 12'h074;
  localparam logic [11:0] ADDR_SPARE_80    = 12'h080;
  localparam logic [11:0] ADDR_PROCID0     = 12'h084;
  localparam logic [11:0] ADDR_PROCID1     = 12'h088;
  localparam logic [11:0] ADDR_SPARE_8C    = 12'h08c;
  localparam logic [11:0] ADDR_SPARE_90    = 12'h090;
  localparam logic [11:0] ADDR_SPARE_94    = 12'h094;
  localparam logic [11:0] ADDR_SPARE_98    = 12'h098;
  localparam logic [11:0] ADDR_SPARE_9C    = 12'h09c;
  localparam logic [11:0] ADDR_SYSCFG_DATA = 12'h0a0;
  localparam logic [11:0] ADDR_SYSCFG_CTRL = 12'h0a4;
  localparam logic [11:0] ADDR_SYSCFG_STAT = 12'h0a8;
  localparam logic [11:0] ADDR_TEST_C0     = 12'h0c0;
  localparam logic [11:0] ADDR_TEST_C4     = 12'h0c4;
  localparam logic [11:0] ADDR_TEST_C8     = 12'h0c8;
  localparam logic [11:0] ADDR_TEST_CC     = 12'h0cc;
  localparam logic [11:0] ADDR_TEST_D0     = 12'h0d0;

  // Register constants
  localparam logic [31:0] UNLOCK_KEY        = 32'h0000_a05f;
  localparam logic [15:0] LOCK_MASK         = 16'h7fff;
  localparam logic [31:0] DISP_KEEP_MASK    = 32'h0000_3f00;
  localparam logic [31:0] DISP_SECOND_MASK  = 32'h0000_0080;
  localparam logic [31:0] DISP_RESET_VALUE  = 32'h0000_1f00;
  localparam logic [31:0] PCICTL_VALUE      = 32'h0000_0001;
  localparam logic [31:0] PROCID1_VALUE     = 32'hff00_0000;
  localparam logic [31:0] SYSCFG_STRIP_MASK = 32'h000c_0000;
  localparam logic [31:0] SYSCFG_SHUTDOWN   = 32'hc080_0000;
  localparam logic [31:0] SYSCFG_REBOOT     = 32'hc090_0000;
  localparam logic [1:0]  SYSCFG_STAT_DONE  = 2'b01;
  localparam logic [1:0]  SYSCFG_STAT_ERR   = 2'b10;
  localparam int unsigned RESETCTL_REQ_BIT  = 8;

  localparam int unsigned CARD_INSERT_BIT   = 0;
  localparam int unsigned CARD_WPROT_BIT    = 1;
  localparam int unsigned CARD_WPROT_BIT_F  = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] register_offset;
    logic [31:0] write_data;
    logic        line_number;
    logic        line_level;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_register;
    logic        reset_request;
    logic        shutdown_request;
    logic        mux_update;
    logic [1:0]  mux_select;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } cfg_write_t;

  function automatic logic [11:0] board_type(input logic [31:0] id_word);
    return id_word[27:16];
  endfunction

  function automatic logic [31:0] disp_reset(input logic [31:0] id_word);
    return (board_type(id_word) == BT_LAST) ? 32'h0 : DISP_RESET_VALUE;
  endfunction

endpackage

// ----- hw/rtl/board_system_control_registers.sv -----
`timescale 1ns / 1ps
// Board system-control register block.
//
// Input channel (in_valid / in_stall / in_item): one transaction per bus read,
// bus write, card line change or timer tick. Output channel (out_valid /
// out_stall / out_item): exactly one result transaction per input transaction,
// in order. Configuration channel (cfg_valid / cfg_ready / cfg_index /
// cfg_data): writes the board ID word (index 0) or processor ID word (index 1);
// cfg_ready is always high. Write configuration only while the block is idle.
//
// The result of a transaction is registered into out_item as it is taken, or
// into the skid entry while the output stalls. Throughput: one transaction per
// cycle while in_stall is low. Register state updates at the edge a transaction
// is taken; the result is computed from the state before that edge.
//
// Stall: the output register plus one skid entry hold up to two results, so a
// new transaction is still taken while one result waits. in_stall rises only
// when both are full and is a plain register output.
//
// Reset (rst_n low, synchronous): state registers clear (not the result data),
// display control loads its board-ID-0 default, both channels drain empty.

module board_system_control_registers
  import bscr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  out_item_t  skid_item_r, skid_item_nxt;
  out_item_t  result;
  cfg_write_t cfg_wr;
  logic       in_fire;
  logic       out_fire;
  logic       slot_free;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  // Output register can load this cycle
  assign slot_free = !out_valid_r || !out_stall;

  bscr_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_en(in_fire),
    .item   (in_item),
    .cfg    (cfg_wr),
    .result (result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (slot_free) begin
      if (skid_valid_r) begin
        // Drain the skid entry first to keep order
        out_valid_nxt  = 1'b1;
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        if (in_fire) out_item_nxt = result;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_take_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && out_stall) |=> (skid_valid_r && out_valid_r))
    else $error("transaction taken while output busy was not kept in skid");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_fire) |=> (!skid_valid_r && out_valid_r))
    else $error("skid entry did not move to output register");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.reset_request && out_item_r.shutdown_request))
    else $error("reset and shutdown requested by one transaction");

  a_mux_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.mux_update) |-> (out_item_r.mux_select == 2'b00))
    else $error("mux select driven without mux update");

endmodule

// ----- hw/rtl/bscr_regs.sv -----
`timescale 1ns / 1ps

module bscr_regs
  import bscr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_en,
  input  in_item_t   item,
  input  cfg_write_t cfg,
  output out_item_t  result
);

  logic [31:0] board_id_r,   board_id_nxt;
  logic [31:0] proc_id_r,    proc_id_nxt;
  logic [31:0] led_r,        led_nxt;
  logic [15:0] lock_r,       lock_nxt;
  logic [31:0] cfgdata1_r,   cfgdata1_nxt;
  logic [31:0] cfgdata2_r,   cfgdata2_nxt;
  logic [31:0] flags_r,      flags_nxt;
  logic [31:0] nvflags_r,    nvflags_nxt;
  logic [31:0] reset_lvl_r,  reset_lvl_nxt;
  logic [2:0]  card_r,       card_nxt;
  logic [31:0] disp_r,       disp_nxt;
  logic [31:0] sc_data_r,    sc_data_nxt;
  logic [31:0] sc_ctrl_r,    sc_ctrl_nxt;
  logic [1:0]  sc_stat_r,    sc_stat_nxt;
  logic [31:0] tick_r,       tick_nxt;

  logic [11:0] bt;
  logic        is_last;
  logic        is_first;
  logic        is_second;
  logic [31:0] wd;
  logic [31:0] sc_val;
  logic [1:0]  card_idx;
  out_item_t   res;

  assign bt        = board_type(board_id_r);
  assign is_last   = (bt == BT_LAST);
  assign is_first  = (bt == BT_MUX) || (bt == BT_NOMUX);
  assign is_second = (bt == BT_SECOND_A) || (bt == BT_SECOND_B);
  assign wd        = item.write_data;
  assign sc_val    = wd & ~SYSCFG_STRIP_MASK;
  assign card_idx  = (item.line_number == LINE_INSERT) ? 2'(CARD_INSERT_BIT) :
                     (is_first ? 2'(CARD_WPROT_BIT_F) : 2'(CARD_WPROT_BIT));

  always_comb begin
    res           = '0;
    board_id_nxt  = board_id_r;
    proc_id_nxt   = proc_id_r;
    led_nxt       = led_r;
    lock_nxt      = lock_r;
    cfgdata1_nxt  = cfgdata1_r;
    cfgdata2_nxt  = cfgdata2_r;
    flags_nxt     = flags_r;
    nvflags_nxt   = nvflags_r;
    reset_lvl_nxt = reset_lvl_r;
    card_nxt      = card_r;
    disp_nxt      = disp_r;
    sc_data_nxt   = sc_data_r;
    sc_ctrl_nxt   = sc_ctrl_r;
    sc_stat_nxt   = sc_stat_r;
    tick_nxt      = tick_r;

    case (item.operation)
      OP_READ: begin
        case (item.register_offset)
          ADDR_ID:       res.read_data = board_id_r;
          ADDR_LED:      res.read_data = led_r;
          ADDR_LOCK:     res.read_data = {16'h0, lock_r};
          ADDR_CFGDATA1: res.read_data = cfgdata1_r;
          ADDR_CFGDATA2: res.read_data = cfgdata2_r;
          ADDR_FLAGS:    res.read_data = flags_r;
          ADDR_NVFLAGS:  res.read_data = nvflags_r;
          ADDR_RESETCTL: res.read_data = is_last ? 32'h0 : reset_lvl_r;
          ADDR_PCICTL:   res.read_data = PCICTL_VALUE;
          ADDR_CARD:     res.read_data = {29'h0, card_r};
          ADDR_DISP:     res.read_data = disp_r;
          ADDR_COUNTER:  res.read_data = tick_r;
          ADDR_PROCID0:  res.read_data = proc_id_r;
          ADDR_PROCID1:  res.read_data = PROCID1_VALUE;
          ADDR_SW, ADDR_OSC0, ADDR_OSC1, ADDR_OSC2, ADDR_OSC3, ADDR_OSC4,
          ADDR_HUNDRED_HZ, ADDR_FLASH, ADDR_DISP_SER, ADDR_BOOTCS, ADDR_SPARE_60,
          ADDR_SPARE_64, ADDR_SPARE_68, ADDR_SPARE_6C, ADDR_SPARE_70, ADDR_SPARE_74,
          ADDR_SPARE_80, ADDR_SPARE_8C, ADDR_SPARE_90, ADDR_SPARE_94, ADDR_SPARE_98,
          ADDR_SPARE_9C, ADDR_TEST_C0, ADDR_TEST_C4, ADDR_TEST_C8, ADDR_TEST_CC,
          ADDR_TEST_D0: res.read_data = 32'h0;
          ADDR_SYSCFG_DATA: begin
            if (is_last) res.read_data = sc_data_r;
            else         res.bad_register = 1'b1;
          end
          ADDR_SYSCFG_CTRL: begin
            if (is_last) res.read_data = sc_ctrl_r;
            else         res.bad_register = 1'b1;
          end
          ADDR_SYSCFG_STAT: begin
            if (is_last) res.read_data = {30'h0, sc_stat_r};
            else         res.bad_register = 1'b1;
          end
          default: res.bad_register = 1'b1;
        endcase
      end

      OP_WRITE: begin
        case (item.register_offset)
          ADDR_LED:         led_nxt      = wd;
          ADDR_LOCK:        lock_nxt     = (wd == UNLOCK_KEY) ? UNLOCK_KEY[15:0]
                                                              : (wd[15:0] & LOCK_MASK);
          ADDR_CFGDATA1:    cfgdata1_nxt = wd;
          ADDR_CFGDATA2:    cfgdata2_nxt = wd;
          ADDR_FLAGS:       flags_nxt    = flags_r | wd;
          ADDR_FLAGS_CLR:   flags_nxt    = flags_r & ~wd;
          ADDR_NVFLAGS:     nvflags_nxt  = nvflags_r | wd;
          ADDR_NVFLAGS_CLR: nvflags_nxt  = nvflags_r & ~wd;
          ADDR_RESETCTL: begin
            // Only taken on non-last board types once the lock word holds the unlock key
            if (!is_last && ({16'h0, lock_r} == UNLOCK_KEY)) begin
              reset_lvl_nxt     = wd;
              res.reset_request = wd[RESETCTL_REQ_BIT];
            end
          end
          ADDR_DISP: begin
            if (is_first) begin
              disp_nxt = (disp_r & DISP_KEEP_MASK) | (wd & ~DISP_KEEP_MASK);
              if (bt == BT_MUX) begin
                res.mux_update = 1'b1;
                res.mux_select = wd[1:0];
              end
            end else if (is_second) begin
              disp_nxt = (disp_r & ~DISP_SECOND_MASK) | (wd & DISP_SECOND_MASK);
            end
          end
          ADDR_OSC0, ADDR_OSC1, ADDR_OSC2, ADDR_OSC3, ADDR_OSC4, ADDR_PCICTL,
          ADDR_FLASH, ADDR_DISP_SER, ADDR_SPARE_64, ADDR_SPARE_68, ADDR_SPARE_6C,
          ADDR_SPARE_70, ADDR_SPARE_74, ADDR_SPARE_80, ADDR_PROCID0, ADDR_PROCID1,
          ADDR_SPARE_8C, ADDR_SPARE_90, ADDR_SPARE_94, ADDR_SPARE_98,
          ADDR_SPARE_9C: ;
          ADDR_SYSCFG_DATA: begin
            if (is_last) sc_data_nxt = wd;
            else         res.bad_register = 1'b1;
          end
          ADDR_SYSCFG_CTRL: begin
            if (is_last) begin
              sc_ctrl_nxt = sc_val;
              if (sc_val == SYSCFG_SHUTDOWN) begin
                sc_stat_nxt          = SYSCFG_STAT_DONE;
                res.shutdown_request = 1'b1;
              end else if (sc_val == SYSCFG_REBOOT) begin
                sc_stat_nxt       = SYSCFG_STAT_DONE;
                res.reset_request = 1'b1;
              end else begin
                sc_stat_nxt = SYSCFG_STAT_DONE | SYSCFG_STAT_ERR;
              end
            end else begin
              res.bad_register = 1'b1;
            end
          end
          ADDR_SYSCFG_STAT: begin
            if (is_last) sc_stat_nxt = wd[1:0];
            else         res.bad_register = 1'b1;
          end
          default: res.bad_register = 1'b1;
        endcase
      end

      OP_LINE: card_nxt[card_idx] = item.line_level;

      OP_TICK: tick_nxt = tick_r + 32'd1;

      default: ;
    endcase

    // Hold all item-driven state unless an item is taken; cfg writes still apply
    if (!item_en) begin
      led_nxt       = led_r;
      lock_nxt      = lock_r;
      cfgdata1_nxt  = cfgdata1_r;
      cfgdata2_nxt  = cfgdata2_r;
      flags_nxt     = flags_r;
      nvflags_nxt   = nvflags_r;
      reset_lvl_nxt = reset_lvl_r;
      card_nxt      = card_r;
      disp_nxt      = disp_r;
      sc_data_nxt   = sc_data_r;
      sc_ctrl_nxt   = sc_ctrl_r;
      sc_stat_nxt   = sc_stat_r;
      tick_nxt      = tick_r;
    end

    if (cfg.en) begin
      case (cfg.index)
        CFG_BOARD_ID: begin
          board_id_nxt = cfg.data;
          disp_nxt     = disp_reset(cfg.data);
        end
        CFG_PROCESSOR_ID: proc_id_nxt = cfg.data;
        default: ;
      endcase
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_id_r  <= '0;
      proc_id_r   <= '0;
      led_r       <= '0;
      lock_r      <= '0;
      cfgdata1_r  <= '0;
      cfgdata2_r  <= '0;
      flags_r     <= '0;
      nvflags_r   <= '0;
      reset_lvl_r <= '0;
      card_r      <= '0;
      disp_r      <= disp_reset(32'h0);
      sc_data_r   <= '0;
      sc_ctrl_r   <= '0;
      sc_stat_r   <= '0;
      tick_r      <= '0;
    end else begin
      board_id_r  <= board_id_nxt;
      proc_id_r   <= proc_id_nxt;
      led_r       <= led_nxt;
      lock_r      <= lock_nxt;
      cfgdata1_r  <= cfgdata1_nxt;
      cfgdata2_r  <= cfgdata2_nxt;
      flags_r     <= flags_nxt;
      nvflags_r   <= nvflags_nxt;
      reset_lvl_r <= reset_lvl_nxt;
      card_r      <= card_nxt;
      disp_r      <= disp_nxt;
      sc_data_r   <= sc_data_nxt;
      sc_ctrl_r   <= sc_ctrl_nxt;
      sc_stat_r   <= sc_stat_nxt;
      tick_r      <= tick_nxt;
    end
  end

endmodule
